// ----- sv/pmd_pkg.sv -----
// Package for the primitive packet decoder: layout table, descriptor type, codes.
// No dependencies.
package pmd_pkg;

  localparam logic [7:0]  KeyMask    = 8'hFD;
  localparam logic [31:0] FixedColor = 32'h0080_8080;
  localparam int unsigned Corners    = 4;

  typedef enum logic [1:0] {
    COL_FIXED  = 2'd0,
    COL_SINGLE = 2'd1,
    COL_PER    = 2'd2
  } col_kind_e;

  typedef struct packed {
    logic      hit;
    logic      tex;
    logic      quad;
    col_kind_e col_kind;
    logic [5:0] col_off;
    logic [5:0] vtx_off;
    logic [2:0] vtx_stride;
  } layout_t;

  // packet descriptor handed from front to back
  typedef struct packed {
    logic        skip;
    logic        tex;
    logic        quad;
    logic        col_fixed;
    logic [7:0]  mode;
    logic [Corners-1:0][15:0] vtx;
    logic [Corners-1:0][7:0]  tu;
    logic [Corners-1:0][7:0]  tv;
    logic [Corners-1:0][31:0] col;
    logic [15:0] pal;
    logic [15:0] page;
  } desc_t;

  function automatic layout_t lay(input logic [7:0] len_exp, input logic [7:0] len,
                                  input logic tex, input logic quad, input col_kind_e ck,
                                  input logic [5:0] coff, input logic [5:0] voff,
                                  input logic [2:0] vstr);
    layout_t l;
    l.hit        = (len == len_exp);
    l.tex        = tex;
    l.quad       = quad;
    l.col_kind   = ck;
    l.col_off    = coff;
    l.vtx_off    = voff;
    l.vtx_stride = vstr;
    return l;
  endfunction

  function automatic layout_t pmd_lookup(input logic [7:0] key, input logic [7:0] len);
    layout_t l;
    l = '0;
    case (key)
      8'h20: l = lay(8'd3,  len, 1'b0, 1'b0, COL_SINGLE, 6'd0,  6'd6,  3'd2);
      8'h21: l = lay(8'd3,  len, 1'b0, 1'b0, COL_SINGLE, 6'd0,  6'd4,  3'd2);
      8'h28: l = lay(8'd4,  len, 1'b0, 1'b1, COL_SINGLE, 6'd0,  6'd6,  3'd2);
      8'h29: l = lay(8'd3,  len, 1'b0, 1'b1, COL_SINGLE, 6'd0,  6'd4,  3'd2);
      8'h24: l = lay(8'd5,  len, 1'b1, 1'b0, COL_FIXED,  6'd0,  6'd14, 3'd2);
      8'h25: l = lay(8'd6,  len, 1'b1, 1'b0, COL_SINGLE, 6'd12, 6'd16, 3'd2);
      8'h2C: l = lay(8'd7,  len, 1'b1, 1'b1, COL_FIXED,  6'd0,  6'd18, 3'd2);
      8'h2D: l = lay(8'd7,  len, 1'b1, 1'b1, COL_SINGLE, 6'd16, 6'd20, 3'd2);
      8'h30: l = lay(8'd4,  len, 1'b0, 1'b0, COL_SINGLE, 6'd0,  6'd6,  3'd4);
      8'h31: l = lay(8'd5,  len, 1'b0, 1'b0, COL_PER,    6'd0,  6'd12, 3'd2);
      8'h34: l = lay(8'd6,  len, 1'b1, 1'b0, COL_FIXED,  6'd0,  6'd14, 3'd4);
      8'h35: l = lay(8'd8,  len, 1'b1, 1'b0, COL_PER,    6'd12, 6'd24, 3'd2);
      8'h38: l = lay(8'd5,  len, 1'b0, 1'b1, COL_SINGLE, 6'd0,  6'd6,  3'd4);
      8'h39: l = lay(8'd6,  len, 1'b0, 1'b1, COL_PER,    6'd0,  6'd16, 3'd2);
      8'h3C: l = lay(8'd8,  len, 1'b1, 1'b1, COL_FIXED,  6'd0,  6'd18, 3'd4);
      8'h3D: l = lay(8'd10, len, 1'b1, 1'b1, COL_PER,    6'd16, 6'd32, 3'd2);
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

// ----- sv/pmd_word_if.sv -----
// Request channel carrying packet words.
// No dependencies.
interface pmd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  modport source (output valid, output packet_word, input ready);
  modport sink (input valid, input packet_word, output ready);
endinterface

// ----- sv/pmd_corner_if.sv -----
// Request channel carrying decoded corner results.
// No dependencies.
interface pmd_corner_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_index;
  logic [7:0]  tex_u;
  logic [7:0]  tex_v;
  logic [31:0] corner_color;
  logic [9:0]  palette_x;
  logic [8:0]  palette_y;
  logic [1:0]  blend_mode;
  logic [1:0]  texture_depth;
  logic [3:0]  prim_flags;
  logic [7:0]  packet_mode;
  logic        status;
  logic        last;
  modport source (output valid, output vertex_index, output tex_u, output tex_v,
                  output corner_color, output palette_x, output palette_y,
                  output blend_mode, output texture_depth, output prim_flags,
                  output packet_mode, output status, output last, input ready);
  modport sink (input valid, input vertex_index, input tex_u, input tex_v,
                input corner_color, input palette_x, input palette_y,
                input blend_mode, input texture_depth, input prim_flags,
                input packet_mode, input status, input last, output ready);
endinterface

// ----- sv/pmd_front.sv -----
// Front end: parses headers, captures body fields per corner lane, builds descriptors.
// Depends on pmd_pkg.
module pmd_front import pmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] word_i,
  output logic        ready_o,
  input  logic        full_i,
  output logic        push_o,
  output desc_t       desc_o
);

  logic       in_body_q, in_body_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] len_q, mode_q;
  layout_t    lay_q, lay_hdr, lay_sel;
  logic [Corners-1:0][15:0] vtx_q, vtx_d;
  logic [Corners-1:0][7:0]  tu_q, tu_d, tv_q, tv_d;
  logic [Corners-1:0][31:0] col_q, col_d;
  logic [15:0] pal_q, pal_d, page_q, page_d;
  logic        acc, done;
  logic [7:0]  seen_inc;
  logic [5:0]  vb;
  logic [3:0]  cw;

  assign ready_o  = !full_i;
  assign acc      = valid_i && ready_o;
  assign lay_hdr  = pmd_lookup(word_i[31:24] & KeyMask, word_i[15:8]);
  assign seen_inc = seen_q + 8'd1;

  always_comb begin
    vtx_d  = vtx_q;
    tu_d   = tu_q;
    tv_d   = tv_q;
    col_d  = col_q;
    pal_d  = pal_q;
    page_d = page_q;
    vb     = '0;
    cw     = '0;
    if (acc && in_body_q) begin
      for (int i = 0; i < Corners; i++) begin
        vb = lay_q.vtx_off + 6'(lay_q.vtx_stride * i);
        if (seen_q == {4'd0, vb[5:2]}) begin
          vtx_d[i] = vb[1] ? word_i[31:16] : word_i[15:0];
        end
        if (seen_q == 8'(i)) begin
          tu_d[i] = word_i[7:0];
          tv_d[i] = word_i[15:8];
        end
        cw = lay_q.col_off[5:2] + ((lay_q.col_kind == COL_PER) ? 4'(i) : 4'd0);
        if (seen_q == {4'd0, cw}) begin
          col_d[i] = word_i;
        end
      end
      if (seen_q == 8'd0) pal_d = word_i[31:16];
      if (seen_q == 8'd1) page_d = word_i[31:16];
    end
  end

  always_comb begin
    in_body_d = in_body_q;
    seen_d    = seen_q;
    done      = 1'b0;
    if (acc) begin
      if (!in_body_q) begin
        seen_d    = '0;
        in_body_d = (word_i[15:8] != 8'd0);
        done      = (word_i[15:8] == 8'd0);
      end else begin
        seen_d = seen_inc;
        if (seen_inc == len_q) begin
          in_body_d = 1'b0;
          done      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    lay_sel          = in_body_q ? lay_q : lay_hdr;
    desc_o.skip      = !lay_sel.hit;
    desc_o.tex       = lay_sel.tex;
    desc_o.quad      = lay_sel.quad;
    desc_o.col_fixed = (lay_sel.col_kind == COL_FIXED);
    desc_o.mode      = in_body_q ? mode_q : word_i[31:24];
    desc_o.vtx       = vtx_d;
    desc_o.tu        = lay_sel.tex ? tu_d : '0;
    desc_o.tv        = lay_sel.tex ? tv_d : '0;
    desc_o.col       = col_d;
    desc_o.pal       = lay_sel.tex ? pal_d : '0;
    desc_o.page      = lay_sel.tex ? page_d : '0;
  end

  assign push_o = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      seen_q    <= '0;
    end else begin
      in_body_q <= in_body_d;
      seen_q    <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_q  <= vtx_d;
    tu_q   <= tu_d;
    tv_q   <= tv_d;
    col_q  <= col_d;
    pal_q  <= pal_d;
    page_q <= page_d;
    if (acc && !in_body_q) begin
      len_q  <= word_i[15:8];
      mode_q <= word_i[31:24];
      lay_q  <= lay_hdr;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !in_body_q && word_i[15:8] != 8'd0) |=> (in_body_q && seen_q == 8'd0))
    else $error("header did not open body");

endmodule

// ----- sv/pmd_fifo.sv -----
// Two-entry descriptor queue between front and back.
// Depends on pmd_pkg.
module pmd_fifo import pmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t data_o
);

  desc_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

// ----- sv/pmd_back.sv -----
// Back end: walks the corners of each descriptor into a registered output.
// Depends on pmd_pkg.
module pmd_back import pmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  empty_i,
  input  desc_t desc_i,
  output logic  pop_o,
  pmd_corner_if.source out_if
);

  logic [1:0] corner_q;
  logic       valid_q, load, last;
  logic [15:0] vtx_q;
  logic [7:0]  tu_q, tv_q, mode_q;
  logic [31:0] col_q;
  logic [9:0]  px_q;
  logic [8:0]  py_q;
  logic [1:0]  bl_q, dp_q;
  logic [3:0]  fl_q;
  logic        st_q, last_q;

  assign load  = !empty_i && (!valid_q || out_if.ready);
  assign last  = desc_i.skip || (corner_q == (desc_i.quad ? 2'd3 : 2'd2));
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      corner_q <= '0;
    end else begin
      if (load) valid_q <= 1'b1;
      else if (out_if.ready) valid_q <= 1'b0;
      if (load) corner_q <= last ? 2'd0 : corner_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q <= desc_i.mode;
      st_q   <= desc_i.skip;
      last_q <= last;
      if (desc_i.skip) begin
        vtx_q <= '0; tu_q <= '0; tv_q <= '0; col_q <= '0;
        px_q  <= '0; py_q <= '0; bl_q <= '0; dp_q <= '0; fl_q <= '0;
      end else begin
        vtx_q <= desc_i.vtx[corner_q];
        tu_q  <= desc_i.tu[corner_q];
        tv_q  <= desc_i.tv[corner_q];
        col_q <= desc_i.col_fixed ? FixedColor : desc_i.col[corner_q];
        px_q  <= {desc_i.pal[5:0], 4'd0};
        py_q  <= desc_i.pal[14:6];
        bl_q  <= desc_i.page[6:5];
        dp_q  <= desc_i.page[8:7];
        fl_q  <= {desc_i.mode[0], desc_i.mode[1], desc_i.quad, desc_i.tex};
      end
    end
  end

  assign out_if.valid         = valid_q;
  assign out_if.vertex_index  = vtx_q;
  assign out_if.tex_u         = tu_q;
  assign out_if.tex_v         = tv_q;
  assign out_if.corner_color  = col_q;
  assign out_if.palette_x     = px_q;
  assign out_if.palette_y     = py_q;
  assign out_if.blend_mode    = bl_q;
  assign out_if.texture_depth = dp_q;
  assign out_if.prim_flags    = fl_q;
  assign out_if.packet_mode   = mode_q;
  assign out_if.status        = st_q;
  assign out_if.last          = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && st_q) |-> last_q)
    else $error("skip request without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && desc_i.skip) |-> (corner_q == 2'd0))
    else $error("skip descriptor mid-packet");

endmodule

// ----- sv/model_primitive_packet_decoder.sv -----
// Primitive packet decoder top: front parser, descriptor queue, corner emitter.
// A packet's descriptor goes into the queue, then into the output register.
// Throughput: one word in and one corner request out per cycle, the latter while
// out_if.ready holds; the input stalls only while both queue entries hold packets
// the back end has not finished.
// Reset clears parser state, queue and output valid; payload is not reset.
module model_primitive_packet_decoder import pmd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pmd_word_if.sink     in_if,
  pmd_corner_if.source out_if
);

  logic  full, empty, push, pop;
  desc_t desc_in, desc_out;

  pmd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_if.valid),
    .word_i  (in_if.packet_word),
    .ready_o (in_if.ready),
    .full_i  (full),
    .push_o  (push),
    .desc_o  (desc_in)
  );

  pmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (desc_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (desc_out)
  );

  pmd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .desc_i  (desc_out),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule
